/* src/fvd_pkg.sv */
package fvd_pkg;

    // FNV-1a 64-bit constants. The prime is 2^40 + 0x1B3, so the multiply
    // splits into a 40-bit shift and a small 9-bit constant product.
    localparam logic [63:0] FNV_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam int          FNV_PRIME_SHIFT  = 40;
    localparam logic [8:0]  FNV_PRIME_LOW    = 9'h1B3;

    localparam int KIND_W  = 3;
    localparam int COUNT_W = 4;

    localparam logic [KIND_W-1:0] KIND_BYTE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INT32 = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INT64 = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FLT32 = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FLT64 = 3'd4;

    localparam logic [COUNT_W-1:0] BYTES_NONE = 4'd0;
    localparam logic [COUNT_W-1:0] BYTES_ONE  = 4'd1;
    localparam logic [COUNT_W-1:0] BYTES_FOUR = 4'd4;
    localparam logic [COUNT_W-1:0] BYTES_EIGHT = 4'd8;

    // One classified item as it waits between the front and the back.
    typedef struct packed {
        logic               start;
        logic               last;
        logic               inf_nan;
        logic [COUNT_W-1:0] byte_count;
        logic [63:0]        bits;
    } item_t;

endpackage

/* src/typed_value_fnv1a_digest_core.sv */
// Flow: an item with N folded bytes (0, 1, 4 or 8) passes through the queue into
// the back end, which loads it, folds its bytes and then finishes it; only the last
// item of a digest shows its digest on m_tdata. The back end folds one byte per cycle
// through a single xor-multiply round and takes no new item until the current one is done.
// Reset: rst_n is asynchronous and active low; it empties the queue, drops the
// output beat, loads the FNV offset basis and clears the non-finite flag.
module typed_value_fnv1a_digest_core
    import fvd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value
    input  logic [3:0]  s_tuser,   // start_digest, value_kind[2:0]
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // digest[63:0], status, seven zero bits
);

    // The front end classifies each beat as it arrives: it works out how many
    // bytes the kind contributes, folds negative zero floats to positive zero
    // and flags floats whose exponent is all ones. Classified items wait in a
    // short queue so that the input side keeps accepting beats while the back
    // end is still busy folding bytes of an earlier item.
    logic  push_valid, push_ready;
    item_t push_item;
    logic  pop_valid, pop_ready;
    item_t pop_item;

    fvd_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    fvd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // The back end owns the running hash and the sticky non-finite flag. A
    // start marker reloads the offset basis when its item is taken from the
    // queue. Bytes are folded least significant first, one per cycle. When
    // the last item of a digest finishes, the hash and status move into an
    // output register, which holds the beat until the sink takes it; the
    // back end stalls only if a second digest finishes before that.
    fvd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* src/fvd_front.sv */
module fvd_front
    import fvd_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value
    input  logic [3:0]  s_tuser,   // start_digest, value_kind[2:0]
    input  logic        s_tlast,   // last_item
    output logic        push_valid,
    input  logic        push_ready,
    output item_t       push_item
);

    logic [KIND_W-1:0] kind;
    logic [31:0]       f32;

    assign kind = s_tuser[3:1];
    assign f32  = s_tdata[31:0];

    // Canonicalize floats, flag non-finite ones and pick how many bytes the back end folds.
    always_comb
    begin
        push_item.start      = s_tuser[0];
        push_item.last       = s_tlast;
        push_item.inf_nan    = 1'b0;
        push_item.byte_count = BYTES_NONE;
        push_item.bits       = s_tdata;
        case (kind)
            KIND_BYTE:
            begin
                push_item.byte_count = BYTES_ONE;
            end
            KIND_INT32:
            begin
                push_item.byte_count = BYTES_FOUR;
            end
            KIND_INT64:
            begin
                push_item.byte_count = BYTES_EIGHT;
            end
            KIND_FLT32:
            begin
                push_item.byte_count = BYTES_FOUR;
                push_item.inf_nan    = &f32[30:23];
                push_item.bits       = (f32 == 32'h8000_0000) ? 64'd0 : {32'd0, f32};
            end
            KIND_FLT64:
            begin
                push_item.byte_count = BYTES_EIGHT;
                push_item.inf_nan    = &s_tdata[62:52];
                push_item.bits = (s_tdata == 64'h8000_0000_0000_0000) ? 64'd0 : s_tdata;
            end
            default:
            begin
                push_item.byte_count = BYTES_NONE;
            end
        endcase
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

/* src/fvd_queue.sv */
module fvd_queue
    import fvd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push, pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/fvd_back.sv */
module fvd_back
    import fvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  item_t       pop_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // digest[63:0], status, zero fill
);

    logic               busy_reg, busy_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [63:0]        bits_reg, bits_next;
    logic               last_reg, last_next;
    logic [63:0]        hash_reg, hash_next;
    logic               nf_reg, nf_next;
    logic               out_valid_reg, out_valid_next;
    logic [63:0]        out_digest_reg, out_digest_next;
    logic               out_status_reg, out_status_next;

    logic [63:0] mixed;
    logic [63:0] folded;
    logic        pop;

    // One FNV-1a round: xor the low byte in, then multiply by the prime.
    assign mixed  = hash_reg ^ {56'd0, bits_reg[7:0]};
    assign folded = (mixed << FNV_PRIME_SHIFT) + mixed * {55'd0, FNV_PRIME_LOW};

    assign pop_ready = !busy_reg;
    assign pop       = pop_valid && !busy_reg;

    always_comb
    begin
        busy_next       = busy_reg;
        count_next      = count_reg;
        bits_next       = bits_reg;
        last_next       = last_reg;
        hash_next       = hash_reg;
        nf_next         = nf_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_digest_next = out_digest_reg;
        out_status_next = out_status_reg;

        if (pop)
        begin
            busy_next  = 1'b1;
            count_next = pop_item.byte_count;
            bits_next  = pop_item.bits;
            last_next  = pop_item.last;
            if (pop_item.start)
            begin
                hash_next = FNV_OFFSET_BASIS;
                nf_next   = pop_item.inf_nan;
            end
            else
            begin
                nf_next = nf_reg | pop_item.inf_nan;
            end
        end
        else if (busy_reg && (count_reg != BYTES_NONE))
        begin
            hash_next  = folded;
            bits_next  = bits_reg >> 8;
            count_next = count_reg - 1'b1;
        end
        else if (busy_reg)
        begin
            if (!last_reg)
            begin
                busy_next = 1'b0;
            end
            else if (!out_valid_reg || m_tready)
            begin
                busy_next       = 1'b0;
                out_valid_next  = 1'b1;
                out_digest_next = hash_reg;
                out_status_next = nf_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= BYTES_NONE;
            last_reg      <= 1'b0;
            hash_reg      <= FNV_OFFSET_BASIS;
            nf_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            hash_reg      <= hash_next;
            nf_reg        <= nf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg       <= bits_next;
        out_digest_reg <= out_digest_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_status_reg, out_digest_reg};

endmodule
